@@ src/assert_macros.svh @@
// Assertion macros shared by the RTL of the sample conditioner.
// Needs nothing else; each macro takes the clock and active-low reset by name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every rising clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("assertion failed");

// Antecedent in this cycle implies consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

// Antecedent implies consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

`endif

@@ src/masc_pkg.sv @@
// Package for the multichannel sample conditioner: sizes, codes and beat types.
// Depends on nothing.
`timescale 1ns / 1ps

package masc_pkg;

    // Block sizing
    localparam int CHANNELS = 12;
    localparam int WINDOW   = 300;

    localparam int CH_IDX_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SCAN_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;

    // Field and state widths
    localparam int CHAN_W  = 4;
    localparam int SAMPLE_W = 16;
    localparam int VALUE_W = 16;
    localparam int EMA_W   = 24;
    localparam int SUM_W   = 25;
    localparam int ALPHA_W = 17;
    localparam int MODE_W  = 2;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 17;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE   = 17'h10000;
    localparam logic [ALPHA_W-1:0] ALPHA_RESET = 17'd6554;
    localparam logic [SUM_W-1:0]   SUM_MAX     = 25'h1FFFFFF;
    localparam logic [VALUE_W-1:0] VALUE_MAX   = 16'hFFFF;

    // Reciprocal for sum / WINDOW, exact for every SUM_W-bit sum:
    // q = (s * DIV_MULT) >> DIV_SHIFT with DIV_MULT = ceil(2^DIV_SHIFT / WINDOW).
    localparam int DIV_SHIFT  = SUM_W + $clog2(WINDOW);
    localparam int DIV_MULT_W = 27;
    localparam int DIV_PROD_W = SUM_W + DIV_MULT_W;
    localparam logic [DIV_MULT_W-1:0] DIV_MULT =
        DIV_MULT_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));

    // Filter mode codes; code three behaves as raw
    typedef enum logic [MODE_W-1:0] {
        MODE_EMA   = 2'd0,
        MODE_BLOCK = 2'd1,
        MODE_RAW   = 2'd2
    } mode_t;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_FILTER_MODE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EMA_ALPHA   = 1'd1;

    typedef struct packed {
        logic [CHAN_W-1:0]   channel;
        logic [SAMPLE_W-1:0] sample;
    } in_beat_t;

    typedef struct packed {
        logic [CHAN_W-1:0]  channel_out;
        logic [VALUE_W-1:0] value;
        logic               window_done;
    } out_beat_t;

endpackage

@@ src/multichannel_adc_sample_conditioner.sv @@
// Top level of the multichannel sample conditioner: EMA, block average, raw.
// Depends on masc_pkg and assert_macros.svh.
//
//   channel   dir  handshake             payload
//   in        in   in_valid / in_ready   in_data   (masc_pkg::in_beat_t)
//   out       out  out_valid / out_ready out_data  (masc_pkg::out_beat_t)
//   cfg       in   cfg_we                cfg_index, cfg_data
//
// One beat per cycle sustained while out_ready stays high; each beat passes the
// stage register, then the result register. Per-channel state is read and written
// in the stage, so the next beat always sees the update of the one before it.
// in_ready follows out_ready combinationally: a stalled result holds the
// stage, which then takes no new beat until the result moves on.
// Reset clears all per-channel state, the scan counter and the valid bits, and loads the configuration defaults.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module multichannel_adc_sample_conditioner (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  masc_pkg::in_beat_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output masc_pkg::out_beat_t                 out_data,
    input  logic                                cfg_we,
    input  logic [masc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [masc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import masc_pkg::*;

    // Configuration
    logic [MODE_W-1:0]  mode_reg;
    logic [ALPHA_W-1:0] alpha_reg;

    // Per-channel state
    logic [EMA_W-1:0]   ema_reg [CHANNELS];
    logic [SUM_W-1:0]   sum_reg [CHANNELS];
    logic [VALUE_W-1:0] avg_reg [CHANNELS];
    logic [SCAN_W-1:0]  scan_reg;

    // Pipeline registers
    logic      stage_valid_reg;
    in_beat_t  stage_data_reg;
    logic      out_valid_reg;
    out_beat_t out_data_reg;

    logic advance;
    logic in_range;
    logic [CH_IDX_W-1:0] idx;

    // Datapath
    logic [ALPHA_W-1:0]       alpha_sat;
    logic [EMA_W-1:0]         ema_cur;
    logic [EMA_W-1:0]         smp_q8;
    logic signed [EMA_W:0]    ema_diff;
    logic signed [ALPHA_W:0]  alpha_s;
    logic signed [EMA_W+ALPHA_W+1:0] ema_prod;
    logic signed [EMA_W+ALPHA_W+1:0] ema_acc;
    logic [EMA_W-1:0]         ema_next;
    logic [SUM_W:0]           sum_wide;
    logic [SUM_W-1:0]         sum_sat;
    logic [DIV_PROD_W-1:0]    div_prod;
    logic [DIV_PROD_W-1:0]    div_q;
    logic [VALUE_W-1:0]       avg_calc;
    logic                     window_end;
    logic                     last_channel;
    logic [SUM_W-1:0]         sum_next;
    logic [VALUE_W-1:0]       avg_next;
    logic [SCAN_W-1:0]        scan_next;
    logic                     ema_we;
    logic                     block_we;
    out_beat_t                result;

    // Handshake: stage moves when the result register is free or draining
    assign advance   = stage_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !stage_valid_reg || advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign in_range = 32'(stage_data_reg.channel) < CHANNELS;
    assign idx      = stage_data_reg.channel[CH_IDX_W-1:0];

    // EMA: E + a*(S - E)/2^16, one signed multiply, floor by bit select
    assign alpha_sat = (alpha_reg > ALPHA_ONE) ? ALPHA_ONE : alpha_reg;
    assign ema_cur   = in_range ? ema_reg[idx] : '0;
    assign smp_q8    = {stage_data_reg.sample, 8'd0};
    assign ema_diff  = $signed({1'b0, smp_q8}) - $signed({1'b0, ema_cur});
    assign alpha_s   = $signed({1'b0, alpha_sat});
    assign ema_prod  = (EMA_W+ALPHA_W+2)'(ema_diff) * (EMA_W+ALPHA_W+2)'(alpha_s);
    assign ema_acc   = $signed({3'd0, ema_cur, 16'd0}) + ema_prod;
    assign ema_next  = ema_acc[EMA_W+15:16];

    // Block sum with saturation, then divide by WINDOW via reciprocal
    assign sum_wide = {1'b0, (in_range ? sum_reg[idx] : '0)}
                      + (SUM_W+1)'(stage_data_reg.sample);
    assign sum_sat  = sum_wide[SUM_W] ? SUM_MAX : sum_wide[SUM_W-1:0];
    assign div_prod = DIV_PROD_W'(sum_sat) * DIV_PROD_W'(DIV_MULT);
    assign div_q    = div_prod >> DIV_SHIFT;
    assign avg_calc = (div_q > DIV_PROD_W'(VALUE_MAX)) ? VALUE_MAX : div_q[VALUE_W-1:0];

    assign window_end   = scan_reg >= SCAN_W'(WINDOW - 1);
    assign last_channel = stage_data_reg.channel == CHAN_W'(CHANNELS - 1);

    // Mode select and result
    always_comb
    begin
        ema_we    = 1'b0;
        block_we  = 1'b0;
        sum_next  = sum_sat;
        avg_next  = in_range ? avg_reg[idx] : '0;
        scan_next = scan_reg;
        result.channel_out = stage_data_reg.channel;
        result.value       = '0;
        result.window_done = 1'b0;
        if (in_range)
        begin
            case (mode_reg)
                MODE_EMA:
                begin
                    ema_we       = 1'b1;
                    result.value = ema_next[EMA_W-1:8];
                end
                MODE_BLOCK:
                begin
                    block_we = 1'b1;
                    if (window_end)
                    begin
                        avg_next           = avg_calc;
                        sum_next           = '0;
                        result.window_done = 1'b1;
                    end
                    result.value = avg_next;
                    if (last_channel)
                    begin
                        scan_next = window_end ? '0 : scan_reg + 1'b1;
                    end
                end
                default:
                begin
                    result.value = stage_data_reg.sample;
                end
            endcase
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_EMA;
            alpha_reg <= ALPHA_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_FILTER_MODE: mode_reg  <= cfg_data[MODE_W-1:0];
                CFG_EMA_ALPHA:   alpha_reg <= cfg_data[ALPHA_W-1:0];
                default:         ;
            endcase
        end
    end

    // Per-channel state and scan counter
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                ema_reg[i] <= '0;
                sum_reg[i] <= '0;
                avg_reg[i] <= '0;
            end
            scan_reg <= '0;
        end
        else if (advance)
        begin
            if (ema_we)
            begin
                ema_reg[idx] <= ema_next;
            end
            if (block_we)
            begin
                sum_reg[idx] <= sum_next;
                avg_reg[idx] <= avg_next;
                scan_reg     <= scan_next;
            end
        end
    end

    // Stage register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stage_valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            stage_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            stage_data_reg <= in_data;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= result;
        end
    end

    // Checks
    `ASSERT_ALWAYS(a_scan_bound, clk, rst_n, scan_reg <= SCAN_W'(WINDOW - 1))
    `ASSERT_SAME(a_empty_stage_ready, clk, rst_n, !stage_valid_reg, in_ready)
    `ASSERT_NEXT(a_stage_to_out, clk, rst_n, advance, out_valid_reg)
    `ASSERT_SAME(a_out_of_range, clk, rst_n,
                 out_valid_reg && (32'(out_data_reg.channel_out) >= CHANNELS),
                 (out_data_reg.value == '0) && !out_data_reg.window_done)

endmodule

@@ sim/tb_multichannel_adc_sample_conditioner.sv @@
`timescale 1ns / 1ps
// Testbench for multichannel_adc_sample_conditioner: streams sample beats under random
// sender gaps and receiver stalls, and checks each result beat against a predictor.
// Depends on masc_pkg and the RTL of the block.

module tb_multichannel_adc_sample_conditioner;
    import masc_pkg::*;

    localparam int RESULT_LATENCY = 2;
    localparam int IDLE_LIMIT     = 2000;

    // Mode code three is not in the package; the block treats it as raw
    localparam logic [MODE_W-1:0]   MODE_RESERVED = 2'd3;
    localparam logic [ALPHA_W-1:0]  ALPHA_TOP     = 17'h1FFFF;
    localparam logic [SAMPLE_W-1:0] SAMPLE_TOP    = 16'hFFFF;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_ready;
    in_beat_t              in_data;
    logic                  out_valid;
    logic                  out_ready;
    out_beat_t             out_data;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    // Predicted registers and per-channel filter state
    logic [MODE_W-1:0]  cur_mode;
    logic [ALPHA_W-1:0] cur_alpha;
    logic [EMA_W-1:0]   ema_acc   [CHANNELS];
    logic [SUM_W-1:0]   sum_acc   [CHANNELS];
    logic [VALUE_W-1:0] avg_latch [CHANNELS];
    int                 scan_pos;

    out_beat_t pending_results[$];

    int err_count       = 0;
    int beats_sent      = 0;
    int results_checked = 0;
    int windows_latched = 0;
    int cfg_writes      = 0;
    int burst_left      = 0;
    int max_gap         = 0;
    int stall_level     = 0;
    int idle_cycles     = 0;

    multichannel_adc_sample_conditioner uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Receiver back-pressure: each period opens with a stall of random length
    initial
    begin : rx_stall
        int period;
        int stall_len;
        int pos;
        period    = 1;
        stall_len = 0;
        pos       = 0;
        out_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (pos == 0)
            begin
                period    = $urandom_range(8, 48);
                stall_len = (stall_level == 0) ? 0 :
                            $urandom_range(0, period * stall_level / 4);
            end
            out_ready <= (pos >= stall_len);
            pos = (pos + 1 == period) ? 0 : pos + 1;
        end
    end

    // Watchdog: too long without any beat moving ends the run
    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no beat moved for %0d cycles", $time, IDLE_LIMIT);
            $display("tb_multichannel_adc_sample_conditioner: errors");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int want, input int got);
        $display("%0t: %s: expected %0d, got %0d", $time, what, want, got);
        err_count++;
    endtask

    // Result checker: every result beat against the oldest prediction
    always @(posedge clk)
    begin : result_check
        out_beat_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (pending_results.size() == 0)
                report_mismatch("result beat with none pending, channel", -1,
                                int'(out_data.channel_out));
            else
            begin
                want = pending_results.pop_front();
                results_checked++;
                if (out_data.channel_out !== want.channel_out)
                    report_mismatch("channel_out", int'(want.channel_out),
                                    int'(out_data.channel_out));
                if (out_data.value !== want.value)
                    report_mismatch("value", int'(want.value), int'(out_data.value));
                if (out_data.window_done !== want.window_done)
                    report_mismatch("window_done", int'(want.window_done),
                                    int'(out_data.window_done));
            end
        end
    end

    task automatic reset_predictor();
        cur_mode  = MODE_EMA;
        cur_alpha = ALPHA_RESET;
        for (int c = 0; c < CHANNELS; c++)
        begin
            ema_acc[c]   = '0;
            sum_acc[c]   = '0;
            avg_latch[c] = '0;
        end
        scan_pos = 0;
    endtask

    // Conditions one sample and updates the predicted state
    function automatic out_beat_t condition_sample(input logic [CHAN_W-1:0] ch,
                                                   input logic [SAMPLE_W-1:0] smp);
        out_beat_t        r;
        logic [63:0]      weight;
        logic [63:0]      acc;
        logic [SUM_W:0]   total;
        logic [SUM_W:0]   quot;
        r.channel_out = ch;
        r.value       = '0;
        r.window_done = 1'b0;
        // Out-of-range channels leave every bit of state alone
        if (ch < CHANNELS)
        begin
            case (cur_mode)
                MODE_EMA:
                begin
                    weight = (cur_alpha > ALPHA_ONE) ? 64'(ALPHA_ONE) : 64'(cur_alpha);
                    acc = weight * (64'(smp) << 8)
                        + (64'(ALPHA_ONE) - weight) * 64'(ema_acc[ch]);
                    ema_acc[ch] = acc[16 +: EMA_W];
                    r.value     = ema_acc[ch][EMA_W-1 -: VALUE_W];
                end
                MODE_BLOCK:
                begin
                    total = {1'b0, sum_acc[ch]} + (SUM_W + 1)'(smp);
                    if (total > {1'b0, SUM_MAX})
                        total = {1'b0, SUM_MAX};
                    // Last scan of the window: latch the average and restart the sum
                    if (scan_pos >= WINDOW - 1)
                    begin
                        quot          = total / (SUM_W + 1)'(WINDOW);
                        avg_latch[ch] = (quot > VALUE_MAX) ? VALUE_MAX : quot[VALUE_W-1:0];
                        total         = '0;
                        r.window_done = 1'b1;
                        windows_latched++;
                    end
                    sum_acc[ch] = total[SUM_W-1:0];
                    r.value     = avg_latch[ch];
                    if (ch == CHANNELS - 1)
                        scan_pos = (scan_pos >= WINDOW - 1) ? 0 : scan_pos + 1;
                end
                default:
                    r.value = smp;
            endcase
        end
        return r;
    endfunction

    // Sends one sample beat in bursts with random gaps; valid stays up inside a burst
    task automatic send_beat(input logic [CHAN_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
        int gap;
        @(negedge clk);
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, max_gap);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 24);
        end
        burst_left--;
        in_valid <= 1'b1;
        in_data  <= '{channel: ch, sample: smp};
        do
            @(posedge clk);
        while (!in_ready);
        pending_results.push_back(condition_sample(ch, smp));
        beats_sent++;
    endtask

    // Holds the sender until every predicted result has come back
    task automatic drain_results();
        @(negedge clk);
        in_valid <= 1'b0;
        burst_left = 0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (RESULT_LATENCY + 2) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        drain_results();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        if (idx == CFG_FILTER_MODE)
            cur_mode = data[MODE_W-1:0];
        else
            cur_alpha = data[ALPHA_W-1:0];
        cfg_writes++;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic set_idling(input int gap, input int stall);
        max_gap     = gap;
        stall_level = stall;
    endtask

    // Extremes show up often, the rest is uniform
    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 7);
        if (roll == 0)
            return '0;
        if (roll == 1)
            return SAMPLE_TOP;
        return SAMPLE_W'($urandom_range(0, 65535));
    endfunction

    // One scan in channel order, optionally salted with stray beats on any channel
    task automatic send_scan(input bit noisy);
        for (int ch = 0; ch < CHANNELS; ch++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_beat(CHAN_W'($urandom_range(0, 15)), SAMPLE_W'($urandom));
            send_beat(CHAN_W'(ch), pick_sample());
        end
    endtask

    // Last-channel beats only, until the next scan closes the window (block mode)
    task automatic fast_forward_window();
        while (scan_pos != WINDOW - 1)
            send_beat(CHAN_W'(CHANNELS - 1), pick_sample());
    endtask

    // Field extremes, every mode, alpha limits and out-of-range channels
    task automatic test_directed();
        set_idling(0, 0);
        // reset settings: EMA at the default weight
        send_beat(4'd0, SAMPLE_TOP);
        send_beat(4'd0, SAMPLE_TOP);
        send_beat(CHAN_W'(CHANNELS - 1), '0);
        send_beat(4'hF, SAMPLE_TOP);
        send_beat(CHAN_W'(CHANNELS), 16'h1234);
        // unity weight, weight above one, zero weight
        write_reg(CFG_EMA_ALPHA, ALPHA_ONE);
        send_beat(4'd1, 16'hA5A5);
        send_beat(4'd2, '0);
        write_reg(CFG_EMA_ALPHA, ALPHA_TOP);
        send_beat(4'd3, 16'h5A5A);
        write_reg(CFG_EMA_ALPHA, '0);
        send_beat(4'd3, SAMPLE_TOP);
        send_beat(4'd1, '0);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_RAW));
        send_beat(4'd0, SAMPLE_TOP);
        send_beat(CHAN_W'(CHANNELS - 1), '0);
        send_beat(4'hD, 16'h8001);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_RESERVED));
        send_beat(4'd5, 16'h1357);
        send_beat(4'hE, SAMPLE_TOP);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_BLOCK));
        send_beat(4'd0, SAMPLE_TOP);
        send_beat(4'd1, 16'h0001);
        send_beat(CHAN_W'(CHANNELS - 1), SAMPLE_TOP);
        send_beat(4'hF, 16'h7FFF);
    endtask

    // EMA over random scans at several weights and idling levels
    task automatic test_ema_random();
        logic [ALPHA_W-1:0] alpha;
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_EMA));
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: alpha = ALPHA_ONE;
                1: alpha = ALPHA_TOP;
                2: alpha = ALPHA_RESET;
                3: alpha = ALPHA_W'($urandom_range(0, 65536));
                default: alpha = ALPHA_W'($urandom_range(0, 131071));
            endcase
            write_reg(CFG_EMA_ALPHA, alpha);
            set_idling($urandom_range(0, 6), p % 4);
            repeat (7) send_scan(1);
        end
    endtask

    task automatic test_raw_modes();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_RAW));
        set_idling(3, 2);
        repeat (4) send_scan(1);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_RESERVED));
        set_idling(0, 1);
        repeat (4) send_scan(1);
    endtask

    // Block average across two window boundaries, with a detour through EMA
    task automatic test_block_average();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_BLOCK));
        set_idling(4, 1);
        repeat (5) send_scan(1);
        // partial window and scan position must hold while another mode runs
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_EMA));
        repeat (2) send_scan(1);
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_BLOCK));
        repeat (2) send_scan(1);
        set_idling(2, 3);
        fast_forward_window();
        send_scan(0);
        repeat (4) send_scan(1);
        set_idling(0, 0);
        fast_forward_window();
        send_scan(0);
        repeat (2) send_scan(1);
    endtask

    // Full-scale beats on one channel out of scan order saturate its sum and average
    task automatic test_sum_saturation();
        write_reg(CFG_FILTER_MODE, CFG_DATA_W'(MODE_BLOCK));
        set_idling(1, 2);
        repeat (520) send_beat(4'd3, SAMPLE_TOP);
        fast_forward_window();
        send_scan(0);
        send_scan(1);
    endtask

    initial
    begin
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_data   = '0;
        cfg_we    = 1'b0;
        cfg_index = CFG_FILTER_MODE;
        cfg_data  = '0;
        reset_predictor();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_ema_random();
        test_raw_modes();
        test_block_average();
        test_sum_saturation();

        // let stragglers show up, then look for predictions never matched
        drain_results();
        repeat (RESULT_LATENCY * 4) @(posedge clk);
        if (pending_results.size() != 0)
            report_mismatch("results never delivered", 0, pending_results.size());

        $display("covered %0d sample beats, %0d results checked, %0d averages latched",
                 beats_sent, results_checked, windows_latched);
        $display("%0d register writes across EMA, block, raw and reserved modes", cfg_writes);
        if (err_count == 0)
            $display("tb_multichannel_adc_sample_conditioner: clean");
        else
            $display("tb_multichannel_adc_sample_conditioner: errors");
        $finish;
    end

endmodule

@@ files.f @@
+incdir+src
src/masc_pkg.sv
src/multichannel_adc_sample_conditioner.sv
sim/tb_multichannel_adc_sample_conditioner.sv
